// ===== rtl/wfod_pkg.sv =====
// Shared types, register indexes and fixed-point helpers for the wheel odometry decoder.
// Used by every module of the block except wfod_fifo; depends on nothing.
package wfod_pkg;

	// Request kinds on the input channel
	localparam logic [1:0] REQ_FRAME = 2'd0;
	localparam logic [1:0] REQ_TICK  = 2'd1;
	localparam logic [1:0] REQ_REARM = 2'd2;

	// Result status codes
	localparam logic [2:0] ST_IGNORED   = 3'd0;
	localparam logic [2:0] ST_VEL_SET   = 3'd1;
	localparam logic [2:0] ST_POS_REF   = 3'd2;
	localparam logic [2:0] ST_POS_MOVED = 3'd3;
	localparam logic [2:0] ST_TICK      = 3'd4;
	localparam logic [2:0] ST_REARMED   = 3'd5;

	// Configuration register indexes
	localparam logic [2:0] REG_WHEEL0_ID     = 3'd0;
	localparam logic [2:0] REG_WHEEL1_ID     = 3'd1;
	localparam logic [2:0] REG_WHEEL0_VSCALE = 3'd2;
	localparam logic [2:0] REG_WHEEL1_VSCALE = 3'd3;
	localparam logic [2:0] REG_WHEEL0_PSCALE = 3'd4;
	localparam logic [2:0] REG_WHEEL1_PSCALE = 3'd5;
	localparam logic [2:0] REG_TIMEOUT       = 3'd6;

	// Frame decode constants
	localparam logic [20:0] KIND_SPEED = 21'd9;
	localparam logic [20:0] KIND_TACHO = 21'd27;
	localparam logic [3:0]  DLC_FULL   = 4'd8;

	// Fixed point: Q8.24 scales, results with FRAC_BITS fraction bits
	localparam int SCALE_FRAC = 24;
	localparam int FRAC_BITS  = 16;
	localparam int RND_SHIFT  = SCALE_FRAC - FRAC_BITS;
	localparam logic signed [63:0] RND_HALF = (64'sd1 <<< RND_SHIFT) >>> 1;
	localparam logic signed [65:0] SAT_MAX = 66'sh7FFF_FFFF_FFFF;
	localparam logic signed [65:0] SAT_MIN = -66'sh8000_0000_0000;

	// Defaults for top-level parameters
	localparam int AGE_BITS_DEF  = 16;
	localparam int MID_DEPTH_DEF = 2;
	localparam int OUT_DEPTH_DEF = 4;

	typedef enum logic [2:0] {
		OP_IGNORE,
		OP_TICK,
		OP_REARM,
		OP_SPEED,
		OP_TACHO
	} op_t;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [28:0] frame_identifier;
		logic        extended_flag;
		logic        remote_flag;
		logic        error_flag;
		logic [3:0]  data_length;
		logic [31:0] data_word;
	} in_item_t;

	typedef struct packed {
		logic [2:0]         status;
		logic               wheel_index;
		logic signed [47:0] velocity;
		logic signed [47:0] position;
		logic               all_fresh;
	} out_item_t;

	// Classified operation handed from front to back
	typedef struct packed {
		op_t         op;
		logic [1:0]  hit;
		logic [31:0] word;
	} mid_op_t;

	typedef struct packed {
		logic [1:0][7:0]  wheel_id;
		logic [1:0][31:0] vel_scale;
		logic [1:0][31:0] pos_scale;
		logic [15:0]      timeout;
	} cfg_t;

	// Clamp to the signed 48-bit range
	function automatic logic signed [47:0] sat48(input logic signed [65:0] v);
		logic signed [47:0] r;
		if (v > SAT_MAX) begin
			r = SAT_MAX[47:0];
		end else if (v < SAT_MIN) begin
			r = SAT_MIN[47:0];
		end else begin
			r = v[47:0];
		end
		return r;
	endfunction

endpackage

// ===== rtl/wfod_fifo.sv =====
// Small synchronous queue on flip-flops with occupancy count.
// Generic; no package dependency.
module wfod_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  logic [WIDTH-1:0]           wdata,
	output logic                       full,
	input  logic                       pop,
	output logic [WIDTH-1:0]           rdata,
	output logic                       empty,
	output logic [$clog2(DEPTH+1)-1:0] count
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wptr_q;
	logic [PW-1:0]    rptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign count   = count_q;
	assign rdata   = mem_q[rptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;

	// Store written entry
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wptr_q] <= wdata;
		end
	end

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wptr_q <= (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (do_pop) begin
				rptr_q <= (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/wfod_cfg.sv =====
// Configuration register file: wheel ids, Q8.24 scales and freshness timeout.
// Depends on wfod_pkg.
module wfod_cfg (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	output wfod_pkg::cfg_t     cfg
);

	wfod_pkg::cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg     = cfg_q;

	// Write the addressed register on each transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.wheel_id[0]  <= 8'd0;
			cfg_q.wheel_id[1]  <= 8'd1;
			cfg_q.vel_scale[0] <= '0;
			cfg_q.vel_scale[1] <= '0;
			cfg_q.pos_scale[0] <= '0;
			cfg_q.pos_scale[1] <= '0;
			cfg_q.timeout      <= 16'd200;
		end else if (cfg_valid) begin
			case (cfg_index)
				wfod_pkg::REG_WHEEL0_ID:     cfg_q.wheel_id[0]  <= cfg_data[7:0];
				wfod_pkg::REG_WHEEL1_ID:     cfg_q.wheel_id[1]  <= cfg_data[7:0];
				wfod_pkg::REG_WHEEL0_VSCALE: cfg_q.vel_scale[0] <= cfg_data;
				wfod_pkg::REG_WHEEL1_VSCALE: cfg_q.vel_scale[1] <= cfg_data;
				wfod_pkg::REG_WHEEL0_PSCALE: cfg_q.pos_scale[0] <= cfg_data;
				wfod_pkg::REG_WHEEL1_PSCALE: cfg_q.pos_scale[1] <= cfg_data;
				wfod_pkg::REG_TIMEOUT:       cfg_q.timeout      <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

endmodule

// ===== rtl/wfod_front.sv =====
// Request classifier: checks frame format, matches wheel ids and decodes the report kind.
// Depends on wfod_pkg.
module wfod_front (
	input  wfod_pkg::in_item_t request,
	input  wfod_pkg::cfg_t     cfg,
	output wfod_pkg::mid_op_t  op
);

	logic        frame_ok;
	logic [7:0]  ctrl_id;
	logic [20:0] kind;
	logic [1:0]  hit;

	assign ctrl_id  = request.frame_identifier[7:0];
	assign kind     = request.frame_identifier[28:8];
	assign frame_ok = request.extended_flag && !request.remote_flag
		&& !request.error_flag && (request.data_length == wfod_pkg::DLC_FULL);

	// Match the controller id against both wheels
	always_comb begin
		for (int i = 0; i < 2; i++) begin
			hit[i] = (cfg.wheel_id[i] == ctrl_id);
		end
	end

	// Classify the request
	always_comb begin
		op.hit  = hit;
		op.word = request.data_word;
		op.op   = wfod_pkg::OP_IGNORE;
		case (request.req_type)
			wfod_pkg::REQ_TICK:  op.op = wfod_pkg::OP_TICK;
			wfod_pkg::REQ_REARM: op.op = wfod_pkg::OP_REARM;
			wfod_pkg::REQ_FRAME: begin
				if (frame_ok && (hit != 2'b00)) begin
					if (kind == wfod_pkg::KIND_SPEED) begin
						op.op = wfod_pkg::OP_SPEED;
					end else if (kind == wfod_pkg::KIND_TACHO) begin
						op.op = wfod_pkg::OP_TACHO;
					end
				end
			end
			default: op.op = wfod_pkg::OP_IGNORE;
		endcase
	end

endmodule

// ===== rtl/wfod_back.sv =====
// Execution pipeline: per-wheel multiply, rounding, saturating accumulate, ages and freshness.
// Depends on wfod_pkg; feeds the result queue under a credit check.
module wfod_back #(
	parameter int AGE_BITS  = wfod_pkg::AGE_BITS_DEF,
	parameter int OUT_DEPTH = wfod_pkg::OUT_DEPTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  wfod_pkg::mid_op_t              head,
	input  logic                           head_valid,
	output logic                           head_pop,
	input  logic [$clog2(OUT_DEPTH+1)-1:0] out_count,
	input  wfod_pkg::cfg_t                 cfg,
	output logic                           out_push,
	output wfod_pkg::out_item_t            out_item
);

	localparam int CW    = $clog2(OUT_DEPTH + 1);
	localparam int CMP_W = (AGE_BITS > 16) ? AGE_BITS : 16;
	localparam logic [AGE_BITS-1:0] AGE_MAX = {AGE_BITS{1'b1}};

	// Stage 1 state: tachometer reference and seen flags
	logic [31:0]        last_tacho_q [2];
	logic [1:0]         rpm_seen_q;
	logic [1:0]         tacho_seen_q;
	logic [1:0]         rpm_seen_d;
	logic [1:0]         tacho_seen_d;
	logic [1:0]         is_speed;
	logic [1:0]         is_tacho;
	logic [31:0]        diff [2];
	logic signed [31:0] mul_a [2];
	logic signed [31:0] mul_b [2];
	logic signed [63:0] prod [2];
	logic               rep;
	logic [2:0]         status;
	logic               issue;

	// Stage 1 pipeline registers
	logic               valid_s1;
	logic [2:0]         status_s1;
	logic               rep_s1;
	logic               tick_s1;
	logic signed [63:0] prod_s1 [2];
	logic [1:0]         vel_upd_s1;
	logic [1:0]         pos_upd_s1;
	logic [1:0]         rpm_rst_s1;
	logic [1:0]         tacho_rst_s1;
	logic [1:0]         rpm_seen_s1;
	logic [1:0]         tacho_seen_s1;

	// Stage 2 state: wheel kinematics and ages
	logic signed [47:0]  vel_q [2];
	logic signed [47:0]  pos_q [2];
	logic [AGE_BITS-1:0] rpm_age_q [2];
	logic [AGE_BITS-1:0] tacho_age_q [2];
	logic signed [47:0]  vel_d [2];
	logic signed [47:0]  pos_d [2];
	logic [AGE_BITS-1:0] rpm_age_d [2];
	logic [AGE_BITS-1:0] tacho_age_d [2];
	logic signed [63:0]  rnd [2];
	logic signed [65:0]  pos_sum [2];
	logic                fresh;

	// Issue only when the result queue has room for everything in flight
	assign issue    = head_valid
		&& ((CW+1)'(out_count) + (CW+1)'(valid_s1) < (CW+1)'(OUT_DEPTH));
	assign head_pop = issue;

	// Per-wheel operand select and multiply
	always_comb begin
		for (int i = 0; i < 2; i++) begin
			is_speed[i] = (head.op == wfod_pkg::OP_SPEED) && head.hit[i];
			is_tacho[i] = (head.op == wfod_pkg::OP_TACHO) && head.hit[i];
			diff[i]     = head.word - last_tacho_q[i];
			mul_a[i]    = is_tacho[i] ? diff[i] : head.word;
			mul_b[i]    = is_tacho[i] ? cfg.pos_scale[i] : cfg.vel_scale[i];
			prod[i]     = mul_a[i] * mul_b[i];
		end
	end

	// Seen flags after this operation
	always_comb begin
		rpm_seen_d   = rpm_seen_q;
		tacho_seen_d = tacho_seen_q;
		if (head.op == wfod_pkg::OP_REARM) begin
			rpm_seen_d   = '0;
			tacho_seen_d = '0;
		end else begin
			rpm_seen_d   = rpm_seen_q | is_speed;
			tacho_seen_d = tacho_seen_q | is_tacho;
		end
	end

	// Pick the reported wheel and status
	always_comb begin
		rep    = 1'b0;
		status = wfod_pkg::ST_IGNORED;
		case (head.op)
			wfod_pkg::OP_TICK:  status = wfod_pkg::ST_TICK;
			wfod_pkg::OP_REARM: status = wfod_pkg::ST_REARMED;
			wfod_pkg::OP_SPEED: begin
				rep    = !head.hit[0];
				status = wfod_pkg::ST_VEL_SET;
			end
			wfod_pkg::OP_TACHO: begin
				rep    = !head.hit[0];
				status = tacho_seen_q[rep] ? wfod_pkg::ST_POS_MOVED : wfod_pkg::ST_POS_REF;
			end
			default: status = wfod_pkg::ST_IGNORED;
		endcase
	end

	// Hold the last tachometer count per wheel
	always_ff @(posedge clk) begin
		for (int i = 0; i < 2; i++) begin
			if (issue && is_tacho[i]) begin
				last_tacho_q[i] <= head.word;
			end
		end
	end

	// Stage 1 products
	always_ff @(posedge clk) begin
		if (issue) begin
			for (int i = 0; i < 2; i++) begin
				prod_s1[i] <= prod[i];
			end
		end
	end

	// Stage 1 control and seen flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1      <= 1'b0;
			status_s1     <= wfod_pkg::ST_IGNORED;
			rep_s1        <= 1'b0;
			tick_s1       <= 1'b0;
			vel_upd_s1    <= '0;
			pos_upd_s1    <= '0;
			rpm_rst_s1    <= '0;
			tacho_rst_s1  <= '0;
			rpm_seen_s1   <= '0;
			tacho_seen_s1 <= '0;
			rpm_seen_q    <= '0;
			tacho_seen_q  <= '0;
		end else begin
			valid_s1 <= issue;
			if (issue) begin
				status_s1     <= status;
				rep_s1        <= rep;
				tick_s1       <= (head.op == wfod_pkg::OP_TICK);
				vel_upd_s1    <= is_speed;
				pos_upd_s1    <= is_tacho & tacho_seen_q;
				rpm_rst_s1    <= is_speed;
				tacho_rst_s1  <= is_tacho;
				rpm_seen_s1   <= rpm_seen_d;
				tacho_seen_s1 <= tacho_seen_d;
				rpm_seen_q    <= rpm_seen_d;
				tacho_seen_q  <= tacho_seen_d;
			end
		end
	end

	// Round, saturate and accumulate; advance ages
	always_comb begin
		for (int i = 0; i < 2; i++) begin
			rnd[i]     = (prod_s1[i] + wfod_pkg::RND_HALF) >>> wfod_pkg::RND_SHIFT;
			pos_sum[i] = $signed({{18{pos_q[i][47]}}, pos_q[i]})
				+ $signed({{2{rnd[i][63]}}, rnd[i]});
			vel_d[i]   = vel_upd_s1[i]
				? wfod_pkg::sat48($signed({{2{rnd[i][63]}}, rnd[i]})) : vel_q[i];
			pos_d[i]   = pos_upd_s1[i] ? wfod_pkg::sat48(pos_sum[i]) : pos_q[i];
			rpm_age_d[i] = rpm_age_q[i];
			tacho_age_d[i] = tacho_age_q[i];
			if (rpm_rst_s1[i]) begin
				rpm_age_d[i] = '0;
			end else if (tick_s1 && (rpm_age_q[i] != AGE_MAX)) begin
				rpm_age_d[i] = rpm_age_q[i] + 1'b1;
			end
			if (tacho_rst_s1[i]) begin
				tacho_age_d[i] = '0;
			end else if (tick_s1 && (tacho_age_q[i] != AGE_MAX)) begin
				tacho_age_d[i] = tacho_age_q[i] + 1'b1;
			end
		end
	end

	// Freshness over both wheels after this update
	always_comb begin
		fresh = (&rpm_seen_s1) && (&tacho_seen_s1);
		for (int i = 0; i < 2; i++) begin
			if ((CMP_W'(rpm_age_d[i]) > CMP_W'(cfg.timeout))
				|| (CMP_W'(tacho_age_d[i]) > CMP_W'(cfg.timeout))) begin
				fresh = 1'b0;
			end
		end
	end

	// Stage 2 state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 2; i++) begin
				vel_q[i]       <= '0;
				pos_q[i]       <= '0;
				rpm_age_q[i]   <= '0;
				tacho_age_q[i] <= '0;
			end
		end else if (valid_s1) begin
			for (int i = 0; i < 2; i++) begin
				vel_q[i]       <= vel_d[i];
				pos_q[i]       <= pos_d[i];
				rpm_age_q[i]   <= rpm_age_d[i];
				tacho_age_q[i] <= tacho_age_d[i];
			end
		end
	end

	// Form the result for the queue
	assign out_push             = valid_s1;
	assign out_item.status      = status_s1;
	assign out_item.wheel_index = rep_s1;
	assign out_item.velocity    = vel_d[rep_s1];
	assign out_item.position    = pos_d[rep_s1];
	assign out_item.all_fresh   = fresh;

`ifndef ASSERT_OFF
	a_out_room: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> (out_count < CW'(OUT_DEPTH)))
		else $error("result pushed into a full queue");

	a_rearm_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && (status_s1 == wfod_pkg::ST_REARMED))
			|-> ((rpm_seen_s1 == 2'b00) && (tacho_seen_s1 == 2'b00)))
		else $error("rearm left a seen flag set");

	a_vel_seen: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && (status_s1 == wfod_pkg::ST_VEL_SET)) |-> rpm_seen_s1[rep_s1])
		else $error("velocity set without rpm seen");

	a_fresh_seen: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && fresh) |-> ((&rpm_seen_s1) && (&tacho_seen_s1)))
		else $error("fresh reported with a report missing");
`endif

endmodule

// ===== rtl/wheel_feedback_odometry_decoder.sv =====
// Top level of the wheel feedback odometry decoder for two motor controllers.
// Depends on wfod_pkg, wfod_cfg, wfod_front, wfod_fifo and wfod_back.
//
// Usage:
//   Requests (frame, tick or rearm) enter through push/full like a queue write;
//   an item transfers when push is high and full is low. Every request yields
//   exactly one result, read like a queue: the oldest result sits on result
//   while empty is low and transfers when pop is high.
//   Configuration registers are written through cfg_valid/cfg_ready with a
//   register index and data; cfg_ready is always high. Write only while idle.
// Timing:
//   A request passes the classified-op queue and the multiply-stage register
//   before empty goes low; round and accumulate finish as the result enters
//   the result queue. Throughput is one item per cycle, set by the single
//   per-wheel multiplier and accumulator, while the credit check lets it issue.
//   When pop is held low the result queue fills, the back end stops issuing,
//   the op queue fills and full rises; nothing is dropped.
// Reset:
//   arst_n clears queues, velocities, positions, ages and seen flags and loads
//   the register defaults; the tachometer reference is set by the first report.
module wheel_feedback_odometry_decoder #(
	parameter int AGE_BITS  = wfod_pkg::AGE_BITS_DEF,
	parameter int MID_DEPTH = wfod_pkg::MID_DEPTH_DEF,
	parameter int OUT_DEPTH = wfod_pkg::OUT_DEPTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	output logic                 full,
	input  wfod_pkg::in_item_t   request,
	output logic                 empty,
	input  logic                 pop,
	output wfod_pkg::out_item_t  result,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [2:0]           cfg_index,
	input  logic [31:0]          cfg_data
);

	localparam int MID_W = $bits(wfod_pkg::mid_op_t);
	localparam int OUT_W = $bits(wfod_pkg::out_item_t);

	wfod_pkg::cfg_t                 cfg;
	wfod_pkg::mid_op_t              front_op;
	logic [MID_W-1:0]               head_bits;
	logic                           head_empty;
	logic                           head_pop;
	logic [$clog2(MID_DEPTH+1)-1:0] mid_count;
	logic [$clog2(OUT_DEPTH+1)-1:0] out_count;
	logic                           out_push;
	wfod_pkg::out_item_t            out_item;
	logic [OUT_W-1:0]               result_bits;
	logic                           out_full;

	wfod_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	wfod_front u_front (
		.request (request),
		.cfg     (cfg),
		.op      (front_op)
	);

	wfod_fifo #(
		.WIDTH (MID_W),
		.DEPTH (MID_DEPTH)
	) u_mid_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (front_op),
		.full   (full),
		.pop    (head_pop),
		.rdata  (head_bits),
		.empty  (head_empty),
		.count  (mid_count)
	);

	wfod_back #(
		.AGE_BITS  (AGE_BITS),
		.OUT_DEPTH (OUT_DEPTH)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (wfod_pkg::mid_op_t'(head_bits)),
		.head_valid (!head_empty),
		.head_pop   (head_pop),
		.out_count  (out_count),
		.cfg        (cfg),
		.out_push   (out_push),
		.out_item   (out_item)
	);

	wfod_fifo #(
		.WIDTH (OUT_W),
		.DEPTH (OUT_DEPTH)
	) u_out_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (out_push),
		.wdata  (out_item),
		.full   (out_full),
		.pop    (pop),
		.rdata  (result_bits),
		.empty  (empty),
		.count  (out_count)
	);

	assign result = wfod_pkg::out_item_t'(result_bits);

`ifndef ASSERT_OFF
	a_mid_bound: assert property (@(posedge clk) disable iff (!arst_n)
		mid_count <= ($clog2(MID_DEPTH+1))'(MID_DEPTH))
		else $error("op queue count out of range");

	a_out_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		out_push |-> !out_full)
		else $error("result queue overflow");

	a_pop_needs_entry: assert property (@(posedge clk) disable iff (!arst_n)
		head_pop |-> !head_empty)
		else $error("back end issued from an empty op queue");
`endif

endmodule
